>>> src/gnh_pkg.sv
// Shared types, constants and distance helper for the geographic next-hop table.
// Depends on nothing; used by gnh_ram consumers and the top level.
package gnh_pkg;

	localparam int MAX_NBR = 32;
	localparam int COORD_W = 10;
	localparam int ADDR_W  = 16;
	localparam int IDX_W   = $clog2(MAX_NBR);
	localparam int CNT_W   = IDX_W + 1;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int DIST_W  = 2 * COORD_W + 1;
	localparam int CROSS_W = (2 * COORD_W + 2 > 22) ? 2 * COORD_W + 2 : 22;
	localparam int CFG_W   = (ADDR_W > COORD_W) ? ADDR_W : COORD_W;

	localparam logic signed [CROSS_W-1:0] CROSS_FLOOR = CROSS_W'(-1000000);

	localparam logic [1:0] OP_BEACON = 2'd0;
	localparam logic [1:0] OP_GREEDY = 2'd1;
	localparam logic [1:0] OP_PERIM  = 2'd2;

	localparam logic [2:0] ST_REFRESH = 3'd0;
	localparam logic [2:0] ST_INSERT  = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_HOP     = 3'd3;
	localparam logic [2:0] ST_NOHOP   = 3'd4;

	localparam logic [1:0] REG_OWN_X    = 2'd0;
	localparam logic [1:0] REG_OWN_Y    = 2'd1;
	localparam logic [1:0] REG_OWN_ADDR = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} entry_t;

	// Squared Euclidean distance between two points.
	function automatic logic [DIST_W-1:0] dist2(input logic [COORD_W-1:0] ax,
			input logic [COORD_W-1:0] ay, input logic [COORD_W-1:0] bx,
			input logic [COORD_W-1:0] by);
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic signed [DIST_W-1:0] sx;
		logic signed [DIST_W-1:0] sy;
		dx = $signed({1'b0, ax}) - $signed({1'b0, bx});
		dy = $signed({1'b0, ay}) - $signed({1'b0, by});
		sx = dx * dx;
		sy = dy * dy;
		return DIST_W'(sx + sy);
	endfunction

endpackage

>>> src/gnh_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// Generic; no package dependency.
module gnh_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/geographic_next_hop_table.sv
// Geographic next-hop table: neighbor memory, planar memory and the sequencer.
// Depends on gnh_pkg and gnh_ram.
// Greedy queries scan the N neighbor entries; perimeter queries scan the P planar entries,
// then the neighbor entries, one entry per cycle through a single memory read port.
// Beacon: a lookup scan of the neighbor entries, plus pruning of the planar entries
// on insert, where each pair test is a read, a distance step and a compare.
// One item at a time. Reset empties both tables (counts to zero) at once.
module geographic_next_hop_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [1:0]                     wr_index,
	input  logic [gnh_pkg::CFG_W-1:0]      wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     op,
	input  logic [gnh_pkg::ADDR_W-1:0]     node_addr,
	input  logic [gnh_pkg::COORD_W-1:0]    pos_x,
	input  logic [gnh_pkg::COORD_W-1:0]    pos_y,
	input  logic [gnh_pkg::COORD_W-1:0]    entry_x,
	input  logic [gnh_pkg::COORD_W-1:0]    entry_y,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     status,
	output logic [gnh_pkg::ADDR_W-1:0]     next_hop,
	output logic                           resume_greedy
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN = 4'd1;
	localparam logic [3:0] S_BCN  = 4'd2;
	localparam logic [3:0] S_VRD  = 4'd3;
	localparam logic [3:0] S_VDAT = 4'd4;
	localparam logic [3:0] S_WRD  = 4'd5;
	localparam logic [3:0] S_WDAT = 4'd6;
	localparam logic [3:0] S_WCMP = 4'd7;
	localparam logic [3:0] S_SHRD = 4'd8;
	localparam logic [3:0] S_SHWR = 4'd9;
	localparam logic [3:0] S_RES1 = 4'd10;
	localparam logic [3:0] S_RES2 = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	localparam int IW = gnh_pkg::IDX_W;
	localparam int CW = gnh_pkg::CNT_W;
	localparam int XW = gnh_pkg::COORD_W;
	localparam int AW = gnh_pkg::ADDR_W;
	localparam int DW = gnh_pkg::DIST_W;
	localparam int KW = gnh_pkg::CROSS_W;
	localparam int EW = $bits(gnh_pkg::entry_t);

	logic [3:0] state_q;

	logic [XW-1:0] own_x_q, own_y_q;
	logic [AW-1:0] own_addr_q;

	logic [1:0]    op_q;
	logic [AW-1:0] key_q;
	logic [XW-1:0] px_q, py_q, ex_q, ey_q;
	logic          phase2_q, found_q;
	logic [IW-1:0] fidx_q;
	logic [DW-1:0] best_d_q;
	logic signed [KW-1:0] best_c_q;
	logic [AW-1:0] hop_q;
	logic [XW-1:0] hx_q, hy_q;
	logic [2:0]    res_st_q;
	logic          resume_q;

	logic [CW-1:0] nbr_cnt_q, pl_cnt_q;
	logic [CW-1:0] issue_q, v_q, w_q, k_q;
	logic [XW-1:0] vx_q, vy_q;
	logic [DW-1:0] dsv_q, dws_q, dwv_q, dh_q, de_q;

	logic          v_s1, v_s2;
	logic [IW-1:0] idx_s1, idx_s2;
	logic [DW-1:0] d_s2;
	logic signed [KW-1:0] p1_s2, p2_s2;
	logic          match_s2;
	gnh_pkg::entry_t ent_s2;

	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [AW-1:0] next_hop_q;
	logic          resume_out_q;

	gnh_pkg::entry_t nbr_rd, pl_rd, scan_ent, new_ent, pl_wdata;
	logic [EW-1:0]   nbr_rd_raw, pl_rd_raw;
	logic            nbr_we, pl_we;
	logic [IW-1:0]   nbr_waddr, pl_waddr, pl_raddr;
	logic            scan_pl, scan_issue, scan_done, full, out_free;
	logic [CW-1:0]   scan_lim, k_nx;
	logic signed [XW:0] snx, sny, sdx, sdy;
	logic signed [KW-1:0] c_s2;

	assign nbr_rd   = gnh_pkg::entry_t'(nbr_rd_raw);
	assign pl_rd    = gnh_pkg::entry_t'(pl_rd_raw);
	assign new_ent  = '{addr: key_q, x: px_q, y: py_q};
	assign scan_pl  = (op_q == gnh_pkg::OP_PERIM) && !phase2_q;
	assign scan_ent = scan_pl ? pl_rd : nbr_rd;
	assign scan_lim = scan_pl ? pl_cnt_q : nbr_cnt_q;
	assign scan_issue = (state_q == S_SCAN) && (issue_q < scan_lim);
	assign scan_done  = (state_q == S_SCAN) && !scan_issue && !v_s1 && !v_s2;
	assign full = (nbr_cnt_q == CW'(gnh_pkg::MAX_NBR)) || (pl_cnt_q == CW'(gnh_pkg::MAX_NBR));
	assign k_nx = k_q + CW'(1);
	assign out_free = !out_valid_q || !out_stall;
	assign c_s2 = p1_s2 - p2_s2;

	assign snx = $signed({1'b0, scan_ent.x}) - $signed({1'b0, own_x_q});
	assign sny = $signed({1'b0, scan_ent.y}) - $signed({1'b0, own_y_q});
	assign sdx = $signed({1'b0, px_q}) - $signed({1'b0, own_x_q});
	assign sdy = $signed({1'b0, py_q}) - $signed({1'b0, own_y_q});

	always_comb begin
		unique case (state_q)
			S_VRD:   pl_raddr = v_q[IW-1:0];
			S_WRD:   pl_raddr = w_q[IW-1:0];
			S_SHRD:  pl_raddr = k_nx[IW-1:0];
			default: pl_raddr = issue_q[IW-1:0];
		endcase
	end

	always_comb begin
		nbr_we    = (state_q == S_BCN) && (found_q || !full);
		nbr_waddr = found_q ? fidx_q : nbr_cnt_q[IW-1:0];
		pl_we     = 1'b0;
		pl_waddr  = pl_cnt_q[IW-1:0];
		pl_wdata  = new_ent;
		if (state_q == S_BCN && !found_q && !full) begin
			pl_we = 1'b1;
		end else if (state_q == S_SHWR) begin
			pl_we    = 1'b1;
			pl_waddr = k_q[IW-1:0];
			pl_wdata = pl_rd;
		end
	end

	gnh_ram #(.DEPTH(gnh_pkg::MAX_NBR), .WIDTH(EW)) u_nbr_ram (
		.clk   (clk),
		.we    (nbr_we),
		.waddr (nbr_waddr),
		.wdata (new_ent),
		.raddr (issue_q[IW-1:0]),
		.rdata (nbr_rd_raw)
	);

	gnh_ram #(.DEPTH(gnh_pkg::MAX_NBR), .WIDTH(EW)) u_pl_ram (
		.clk   (clk),
		.we    (pl_we),
		.waddr (pl_waddr),
		.wdata (pl_wdata),
		.raddr (pl_raddr),
		.rdata (pl_rd_raw)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_x_q    <= '0;
			own_y_q    <= '0;
			own_addr_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				gnh_pkg::REG_OWN_X:    own_x_q    <= wr_data[XW-1:0];
				gnh_pkg::REG_OWN_Y:    own_y_q    <= wr_data[XW-1:0];
				gnh_pkg::REG_OWN_ADDR: own_addr_q <= wr_data[AW-1:0];
				default: ;
			endcase
		end
	end

	// Scan pipeline: stage 1 is the registered memory read, stage 2 holds the
	// distance, cross-product terms and address match of one entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= scan_issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= issue_q[IW-1:0];
		idx_s2   <= idx_s1;
		d_s2     <= gnh_pkg::dist2(scan_ent.x, scan_ent.y, px_q, py_q);
		p1_s2    <= snx * sdy;
		p2_s2    <= sny * sdx;
		match_s2 <= (scan_ent.addr == key_q);
		ent_s2   <= scan_ent;
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nbr_cnt_q   <= '0;
			pl_cnt_q    <= '0;
			out_valid_q <= 1'b0;
			phase2_q    <= 1'b0;
			found_q     <= 1'b0;
			issue_q     <= '0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						found_q  <= 1'b0;
						phase2_q <= 1'b0;
						issue_q  <= '0;
						if (op == gnh_pkg::OP_BEACON || op == gnh_pkg::OP_GREEDY ||
								op == gnh_pkg::OP_PERIM) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						issue_q <= issue_q + CW'(1);
					end
					if (v_s2) begin
						case (op_q)
							gnh_pkg::OP_BEACON: begin
								if (match_s2) begin
									found_q <= 1'b1;
								end
							end
							gnh_pkg::OP_GREEDY: begin
								if (d_s2 < best_d_q) begin
									found_q <= 1'b1;
								end
							end
							gnh_pkg::OP_PERIM: begin
								if (!phase2_q && c_s2 > best_c_q) begin
									found_q <= 1'b1;
								end
							end
							default: ;
						endcase
					end
					if (scan_done) begin
						case (op_q)
							gnh_pkg::OP_BEACON: state_q <= S_BCN;
							gnh_pkg::OP_PERIM: begin
								if (phase2_q) begin
									state_q <= S_RES1;
								end else if (found_q) begin
									phase2_q <= 1'b1;
									issue_q  <= '0;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_BCN: begin
					if (found_q || full) begin
						state_q <= S_DONE;
					end else begin
						nbr_cnt_q <= nbr_cnt_q + CW'(1);
						pl_cnt_q  <= pl_cnt_q + CW'(1);
						state_q   <= S_VRD;
					end
				end
				S_VRD:  state_q <= (v_q >= pl_cnt_q) ? S_DONE : S_VDAT;
				S_VDAT: state_q <= S_WRD;
				S_WRD: begin
					if (w_q >= pl_cnt_q) begin
						state_q <= S_VRD;
					end else if (w_q != v_q) begin
						state_q <= S_WDAT;
					end
				end
				S_WDAT: state_q <= S_WCMP;
				S_WCMP: begin
					if (dsv_q > dws_q && dsv_q > dwv_q) begin
						state_q <= S_SHRD;
					end else begin
						state_q <= S_WRD;
					end
				end
				S_SHRD: begin
					if (k_nx >= pl_cnt_q) begin
						pl_cnt_q <= pl_cnt_q - CW'(1);
						state_q  <= S_VRD;
					end else begin
						state_q <= S_SHWR;
					end
				end
				S_SHWR: state_q <= S_SHRD;
				S_RES1: state_q <= S_RES2;
				S_RES2: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the current item.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q     <= op;
				key_q    <= node_addr;
				px_q     <= pos_x;
				py_q     <= pos_y;
				ex_q     <= entry_x;
				ey_q     <= entry_y;
				best_d_q <= gnh_pkg::dist2(own_x_q, own_y_q, pos_x, pos_y);
				best_c_q <= gnh_pkg::CROSS_FLOOR;
				res_st_q <= gnh_pkg::ST_NOHOP;
				resume_q <= 1'b0;
			end
			S_SCAN: begin
				if (v_s2) begin
					case (op_q)
						gnh_pkg::OP_BEACON: begin
							if (match_s2 && !found_q) begin
								fidx_q <= idx_s2;
							end
						end
						gnh_pkg::OP_GREEDY: begin
							if (d_s2 < best_d_q) begin
								best_d_q <= d_s2;
								hop_q    <= ent_s2.addr;
							end
						end
						gnh_pkg::OP_PERIM: begin
							if (!phase2_q) begin
								if (c_s2 > best_c_q) begin
									best_c_q <= c_s2;
									hop_q    <= ent_s2.addr;
									hx_q     <= ent_s2.x;
									hy_q     <= ent_s2.y;
								end
							// The hop's position follows the last matching neighbor entry.
							end else if (match_s2) begin
								hx_q <= ent_s2.x;
								hy_q <= ent_s2.y;
							end
						end
						default: ;
					endcase
				end
				if (scan_done) begin
					if (op_q == gnh_pkg::OP_GREEDY && found_q) begin
						res_st_q <= gnh_pkg::ST_HOP;
					end
					if (op_q == gnh_pkg::OP_PERIM && !phase2_q) begin
						key_q <= hop_q;
					end
				end
			end
			S_BCN: begin
				if (found_q) begin
					res_st_q <= gnh_pkg::ST_REFRESH;
				end else if (full) begin
					res_st_q <= gnh_pkg::ST_FULL;
				end else begin
					res_st_q <= gnh_pkg::ST_INSERT;
					v_q      <= '0;
				end
			end
			S_VDAT: begin
				vx_q  <= pl_rd.x;
				vy_q  <= pl_rd.y;
				dsv_q <= gnh_pkg::dist2(own_x_q, own_y_q, pl_rd.x, pl_rd.y);
				w_q   <= '0;
			end
			S_WRD: begin
				if (w_q >= pl_cnt_q) begin
					v_q <= v_q + CW'(1);
				end else if (w_q == v_q) begin
					w_q <= w_q + CW'(1);
				end
			end
			S_WDAT: begin
				dws_q <= gnh_pkg::dist2(pl_rd.x, pl_rd.y, own_x_q, own_y_q);
				dwv_q <= gnh_pkg::dist2(pl_rd.x, pl_rd.y, vx_q, vy_q);
			end
			S_WCMP: begin
				if (dsv_q > dws_q && dsv_q > dwv_q) begin
					k_q <= v_q;
				end else begin
					w_q <= w_q + CW'(1);
				end
			end
			S_SHWR: k_q <= k_nx;
			S_RES1: begin
				dh_q <= gnh_pkg::dist2(hx_q, hy_q, px_q, py_q);
				de_q <= gnh_pkg::dist2(ex_q, ey_q, px_q, py_q);
			end
			S_RES2: begin
				resume_q <= (dh_q <= de_q);
				res_st_q <= gnh_pkg::ST_HOP;
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q     <= res_st_q;
			next_hop_q   <= (res_st_q == gnh_pkg::ST_HOP) ? hop_q : own_addr_q;
			resume_out_q <= resume_q;
		end
	end

	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign next_hop      = next_hop_q;
	assign resume_greedy = resume_out_q;

endmodule
